// ===== hdl/fdr_pkg.sv =====
package fdr_pkg;
    localparam int P_W   = 17;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
endpackage

// ===== hdl/fdr_ram.sv =====
module fdr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== hdl/fdr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fdr_div #(
    parameter int NW = 24,
    parameter int DW = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb begin
        trial     = {rem_reg[DW-1:0], quo_reg[NW-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quo = quo_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end
endmodule

// ===== hdl/fdr_pvalue_adjust_core.sv =====
// Flow: after the closing word, each of the m values is ranked through the shared
//   comparator and divided in the serial divider, then given its suffix minimum;
//   the values of a set of m are handled one after another.
// Throughput: one word per cycle while loading; none accepted while computing or
//   emitting. Results leave one at a time; after each accepted result the next is re-read before it is offered.
// Reset: synchronous active-low aresetn clears the sequencer and the count;
//   the value store holds no reset state.
module fdr_pvalue_adjust_core #(
    parameter int MAX_ITEMS   = 64,
    parameter int P_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [16:0] p_value
    input  logic        s_axis_tlast,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] adjusted_value, [22:17] item_index
    output logic        m_axis_tlast    // last_out
);
    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int PW  = fdr_pkg::P_W;
    localparam int CW  = fdr_pkg::CNT_W;
    localparam int NW  = PW + CW;
    localparam int IDX_W_C = fdr_pkg::IDX_W;
    localparam logic [NW-1:0] ONE = NW'(64'd1 << P_FRAC_BITS);

    // Sequencer states
    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_RRD   = 4'd1;  // address p_j; ST_RWAIT loads it into hold
    localparam logic [3:0] ST_RSCAN = 4'd2;  // count p_i <= p_j
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_MRD   = 4'd4;  // read p_i
    localparam logic [3:0] ST_MSCAN = 4'd5;  // min over q_j with p_j >= p_i
    localparam logic [3:0] ST_OUT   = 4'd6;
    localparam logic [3:0] ST_RWAIT = 4'd7;
    localparam logic [3:0] ST_MWAIT = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;      // m
    logic [CW-1:0] oi_reg, oi_next;        // outer index
    logic [CW-1:0] ii_reg, ii_next;        // inner index (read address)
    logic [CW-1:0] rank_reg, rank_next;
    logic [PW-1:0] hold_reg, hold_next;
    logic [NW-1:0] best_reg, best_next;
    logic          scan_v_reg, scan_v_next;

    // Value store, quotient store and adjusted store (quotients kept in flops-free RAM)
    logic          p_we;
    logic [AW-1:0] p_wa, p_ra, q_wa, q_ra;
    logic [PW-1:0] p_wd, p_rd;
    logic          q_we;
    logic [NW-1:0] q_wd, q_rd;
    logic          a_we;
    logic [PW-1:0] a_wd, a_rd;

    fdr_ram #(.WIDTH(PW), .DEPTH(MAX_ITEMS)) u_p (
        .aclk(aclk), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
        .rd_addr(p_ra), .rd_data(p_rd));
    fdr_ram #(.WIDTH(NW), .DEPTH(MAX_ITEMS)) u_q (
        .aclk(aclk), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
        .rd_addr(q_ra), .rd_data(q_rd));
    fdr_ram #(.WIDTH(PW), .DEPTH(MAX_ITEMS)) u_a (
        .aclk(aclk), .wr_en(a_we), .wr_addr(oi_reg[AW-1:0]), .wr_data(a_wd),
        .rd_addr(ii_reg[AW-1:0]), .rd_data(a_rd));

    logic          div_start, div_done;
    logic [NW-1:0] div_quo;
    logic [NW-1:0] div_num;

    // Latch the rank including the compare that finishes in the start cycle
    fdr_div #(.NW(NW), .DW(CW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(rank_next), .done(div_done), .quo(div_quo));

    logic [CW-1:0] cnt_inc;
    logic          s_acc, m_acc;

    assign cnt_inc = cnt_reg + 1'b1;
    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign m_acc   = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign div_num = NW'(hold_reg) * NW'(cnt_reg);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        oi_next     = oi_reg;
        ii_next     = ii_reg;
        rank_next   = rank_reg;
        hold_next   = hold_reg;
        best_next   = best_reg;
        scan_v_next = 1'b0;
        p_we = 1'b0;
        p_wa = cnt_reg[AW-1:0];
        p_wd = s_axis_tdata[PW-1:0];
        p_ra = ii_reg[AW-1:0];
        q_we = 1'b0;
        q_wa = oi_reg[AW-1:0];
        q_wd = div_quo;
        q_ra = ii_reg[AW-1:0];
        a_we = 1'b0;
        a_wd = best_reg[PW-1:0];
        div_start = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    p_we     = 1'b1;
                    cnt_next = cnt_inc;
                    if (s_axis_tlast || cnt_inc == CW'(MAX_ITEMS)) begin
                        oi_next    = '0;
                        ii_next    = '0;
                        state_next = ST_RRD;
                    end
                end
            end
            ST_RRD: begin
                // address oi presented; wait for data
                p_ra       = oi_reg[AW-1:0];
                state_next = ST_RWAIT;
            end
            ST_RWAIT: begin
                hold_next   = p_rd;
                rank_next   = '0;
                ii_next     = '0;
                state_next  = ST_RSCAN;
            end
            ST_RSCAN: begin
                // issue read ii, compare the one issued in the previous cycle
                if (scan_v_reg && p_rd <= hold_reg) begin
                    rank_next = rank_reg + 1'b1;
                end
                if (ii_reg != cnt_reg) begin
                    ii_next     = ii_reg + 1'b1;
                    scan_v_next = 1'b1;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    q_we = 1'b1;
                    if (oi_reg + 1'b1 == cnt_reg) begin
                        oi_next    = '0;
                        state_next = ST_MRD;
                    end else begin
                        oi_next    = oi_reg + 1'b1;
                        state_next = ST_RRD;
                    end
                end
            end
            ST_MRD: begin
                p_ra       = oi_reg[AW-1:0];
                state_next = ST_MWAIT;
            end
            ST_MWAIT: begin
                hold_next  = p_rd;
                best_next  = ONE;
                ii_next    = '0;
                state_next = ST_MSCAN;
            end
            ST_MSCAN: begin
                if (scan_v_reg && p_rd >= hold_reg && q_rd < best_reg) begin
                    best_next = q_rd;
                end
                if (ii_reg != cnt_reg) begin
                    ii_next     = ii_reg + 1'b1;
                    scan_v_next = 1'b1;
                end else begin
                    a_we = 1'b1;
                    a_wd = (scan_v_reg && p_rd >= hold_reg && q_rd < best_reg)
                         ? q_rd[PW-1:0] : best_reg[PW-1:0];
                    if (oi_reg + 1'b1 == cnt_reg) begin
                        oi_next    = '0;
                        ii_next    = '0;
                        state_next = ST_OUT;
                    end else begin
                        oi_next    = oi_reg + 1'b1;
                        state_next = ST_MRD;
                    end
                end
            end
            ST_OUT: begin
                // ii addresses the adjusted store; a_rd is valid when scan_v set
                if (!scan_v_reg) begin
                    scan_v_next = 1'b1;
                end else if (m_acc) begin
                    if (oi_reg + 1'b1 == cnt_reg) begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        oi_next = oi_reg + 1'b1;
                        ii_next = ii_reg + 1'b1;
                    end
                end else begin
                    scan_v_next = 1'b1;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign m_axis_tvalid = (state_reg == ST_OUT) && scan_v_reg;
    assign m_axis_tdata  = {1'b0, oi_reg[IDX_W_C-1:0], a_rd};
    assign m_axis_tlast  = (oi_reg + 1'b1 == cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            cnt_reg    <= '0;
            oi_reg     <= '0;
            ii_reg     <= '0;
            scan_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            oi_reg     <= oi_next;
            ii_reg     <= ii_next;
            scan_v_reg <= scan_v_next;
        end
        rank_reg <= rank_next;
        hold_reg <= hold_next;
        best_reg <= best_next;
    end

    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> !s_axis_tready)
        else $error("accepting while busy");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_ITEMS))
        else $error("count overflow");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(oi_reg))
        else $error("result dropped");
endmodule

// ===== tb/sv/fdr_pvalue_adjust_core_tb.sv =====
`timescale 1ns / 100ps

module fdr_pvalue_adjust_core_tb;

    localparam int P_W     = fdr_pkg::P_W;
    localparam int IDX_W   = fdr_pkg::IDX_W;
    localparam int MAX_N   = 64;
    localparam int FRAC    = 16;
    localparam int ONE_FIX = 1 << FRAC;

    typedef struct packed {
        logic [P_W-1:0] p_value;
        logic           last_in;
    } pword_t;

    typedef struct packed {
        logic [P_W-1:0]   adj;
        logic [IDX_W-1:0] idx;
        logic             last_out;
    } adjword_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [16:0] p_value
    logic        s_axis_tlast;   // last_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [16:0] adjusted_value, [22:17] item_index
    logic        m_axis_tlast;   // last_out

    fdr_pvalue_adjust_core #(.MAX_ITEMS(MAX_N), .P_FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // stimulus and expectations
    pword_t   pending_q[$];
    adjword_t adjusted_q[$];

    // predictor state: values of the set being loaded
    logic [P_W-1:0] set_vals[MAX_N];
    int             set_len;

    int  err_cnt;
    bit  gen_done;
    bit  drain_pause;     // hold the sender until all results are back
    bit  pause_done;
    int  hold_off_cycles; // long receiver stall, counted in monitor process

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        err_cnt++;
    endtask

    // Benjamini-Hochberg on the closed set: rank with ties at the largest rank,
    // truncating divide, then minimum over all values not below, saturated at 1.0.
    task automatic bh_adjust_set();
        logic [63:0] ratio[MAX_N];
        logic [63:0] best;
        int          rank;
        adjword_t    w;
        for (int j = 0; j < set_len; j++) begin
            rank = 0;
            for (int i = 0; i < set_len; i++)
                if (set_vals[i] <= set_vals[j]) rank++;
            ratio[j] = (64'(set_vals[j]) * 64'(set_len)) / 64'(rank);
        end
        for (int i = 0; i < set_len; i++) begin
            best = 64'(ONE_FIX);
            for (int j = 0; j < set_len; j++)
                if (set_vals[j] >= set_vals[i] && ratio[j] < best) best = ratio[j];
            w.adj      = best[P_W-1:0];
            w.idx      = IDX_W'(i);
            w.last_out = (i == set_len - 1);
            adjusted_q = {adjusted_q, w};
        end
        set_len = 0;
    endtask

    // Predict at acceptance time so the expectation order follows the block.
    task automatic predict_word(input pword_t w);
        set_vals[set_len] = w.p_value;
        set_len++;
        if (w.last_in || set_len == MAX_N) bh_adjust_set();
    endtask

    function automatic logic [P_W-1:0] rand_pval();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 0;
            1:       return P_W'(ONE_FIX);
            2:       return P_W'($urandom_range(ONE_FIX, (1 << P_W) - 1));
            3:       return P_W'($urandom_range(0, 40));
            default: return P_W'($urandom_range(0, ONE_FIX));
        endcase
    endfunction

    task automatic add_set(input int n, input bit dup_heavy);
        pword_t w;
        for (int k = 0; k < n; k++) begin
            w.p_value = (dup_heavy && k > 0 && $urandom_range(0, 1))
                        ? pending_q[$].p_value : rand_pval();
            w.last_in = (k == n - 1);
            pending_q = {pending_q, w};
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stimulus
    initial begin
        pword_t w;
        int     n;
        err_cnt  = 0;
        set_len  = 0;
        gen_done = 0;
        // directed: one-item set, extremes, ties, value above 1.0
        w = '{p_value: 0, last_in: 1};                 pending_q = {pending_q, w};
        w = '{p_value: P_W'(ONE_FIX), last_in: 0};     pending_q = {pending_q, w};
        w = '{p_value: {P_W{1'b1}}, last_in: 0};       pending_q = {pending_q, w};
        w = '{p_value: 0, last_in: 0};                 pending_q = {pending_q, w};
        w = '{p_value: 17'd1000, last_in: 0};          pending_q = {pending_q, w};
        w = '{p_value: 17'd1000, last_in: 0};          pending_q = {pending_q, w};
        w = '{p_value: 17'h0AAAA, last_in: 0};         pending_q = {pending_q, w};
        w = '{p_value: 17'h15555, last_in: 1};         pending_q = {pending_q, w};
        w = '{p_value: 17'd500, last_in: 0};           pending_q = {pending_q, w};
        w = '{p_value: 17'd500, last_in: 1};           pending_q = {pending_q, w};
        // full set without a last mark: closes on the 64th word
        for (int k = 0; k < MAX_N; k++) begin
            w.p_value = rand_pval();
            w.last_in = 1'b0;
            pending_q = {pending_q, w};
        end
        // random sets, mostly small
        while (pending_q.size() < 212) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, MAX_N)
                                             : $urandom_range(1, 8);
            add_set(n, $urandom_range(0, 2) == 0);
        end
        // a short trailing set
        add_set(3, 0);
        gen_done = 1;
    end

    // driver
    int  src_gap;
    int  sent_cnt;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            src_gap       <= 0;
            sent_cnt      <= 0;
            drain_pause   <= 1'b0;
            pause_done    <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_word(pending_q.pop_front());
                sent_cnt <= sent_cnt + 1;
                // pause once mid-run until every expected word is back
                if (sent_cnt >= 120 && !pause_done && adjusted_q.size() != 0) begin
                    drain_pause <= 1'b1;
                    pause_done  <= 1'b1;
                end
            end
            if (drain_pause && adjusted_q.size() == 0 && !(s_axis_tvalid && s_axis_tready))
                drain_pause <= 1'b0;
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the word
            end else if (src_gap > 0 || drain_pause || pending_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (src_gap > 0) src_gap <= src_gap - 1;
            end else begin
                // advance to the next word; an accepted one has already left the queue
                w_next: begin
                    pword_t nw;
                    nw = pending_q[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'b0, nw.p_value};
                    s_axis_tlast  <= nw.last_in;
                    src_gap       <= gap_len();
                end
            end
        end
    end

    // monitor and receiver stalls
    int snk_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready   <= 1'b0;
            snk_gap         <= 0;
            hold_off_cycles <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                adjword_t got, want;
                got.adj      = m_axis_tdata[P_W-1:0];
                got.idx      = m_axis_tdata[P_W+IDX_W-1:P_W];
                got.last_out = m_axis_tlast;
                if (adjusted_q.size() == 0) begin
                    report_mismatch("unexpected word idx", got.idx, -1);
                end else begin
                    want = adjusted_q.pop_front();
                    if (got.adj != want.adj)
                        report_mismatch("adjusted_value", got.adj, want.adj);
                    if (got.idx != want.idx)
                        report_mismatch("item_index", got.idx, want.idx);
                    if (got.last_out != want.last_out)
                        report_mismatch("last_out", got.last_out, want.last_out);
                end
            end
            // one long hold-off on offered results while the sender keeps offering
            if (sent_cnt >= 12 && m_axis_tvalid && hold_off_cycles == 0) begin
                hold_off_cycles <= 3000;
                m_axis_tready   <= 1'b0;
            end else if (hold_off_cycles > 1) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_axis_tready   <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap       <= snk_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                if (hold_off_cycles == 1) hold_off_cycles <= -1;
                m_axis_tready <= 1'b1;
                snk_gap       <= gap_len();
            end
        end
    end

    // reset and end of run
    initial begin
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (gen_done && pending_q.size() == 0 && !s_axis_tvalid);
        wait (adjusted_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (err_cnt == 0 && adjusted_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog: covers the 64-word sets and ~40 sets plus stalls, many times over
    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fdr_pkg.sv
hdl/fdr_ram.sv
hdl/fdr_div.sv
hdl/fdr_pvalue_adjust_core.sv
tb/sv/fdr_pvalue_adjust_core_tb.sv
